// ----- hw/rtl/cdq_pkg.sv -----
// cdq_pkg: shared widths, codes, port bundles and index helpers for the circular deque.
// No dependencies; used by circular_deque, cdq_store and cdq_checker.
package cdq_pkg;

	localparam int SLOTS  = 64;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		ACT_ADD_L   = 3'd0,
		ACT_ADD_R   = 3'd1,
		ACT_DEL_L   = 3'd2,
		ACT_DEL_R   = 3'd3,
		ACT_PEEK_L  = 3'd4,
		ACT_PEEK_R  = 3'd5,
		ACT_IS_EMPT = 3'd6,
		ACT_IS_FULL = 3'd7
	} action_t;

	typedef enum logic [2:0] {
		KIND_VALUE     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_EMPTY     = 3'd2,
		KIND_YES       = 3'd3,
		KIND_NO        = 3'd4,
		KIND_NONE_LEFT = 3'd5
	} kind_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_req_t;

	function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(SLOTS - 1)) r = '0;
		else r = i + IDX_W'(1);
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == '0) r = IDX_W'(SLOTS - 1);
		else r = i - IDX_W'(1);
		return r;
	endfunction

	// held values: (tail - head) mod SLOTS, never above SLOTS-1
	function automatic logic [IDX_W-1:0] occupancy(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] tail);
		logic [IDX_W:0] d;
		if (tail >= head) d = {1'b0, tail} - {1'b0, head};
		else d = {1'b0, tail} + (IDX_W+1)'(SLOTS) - {1'b0, head};
		return d[IDX_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/cdq_store.sv -----
// cdq_store: value store of the deque, one write and one read port, registered read data.
// Depends on cdq_pkg.
module cdq_store (
	input  logic                        clk,
	input  cdq_pkg::wr_req_t            wr,
	input  cdq_pkg::rd_req_t            rd,
	output logic [cdq_pkg::DATA_W-1:0]  rd_data
);

	logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::SLOTS];
	logic [cdq_pkg::DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/circular_deque.sv -----
// circular_deque: top level of the double-ended queue of signed 32-bit values.
// Depends on cdq_pkg and cdq_store.
//
// channel   direction  transfer when        ports
// request   in         start && !busy       action, value
// result    out        strobe (each cycle)  kind, value_res, last
//
// Timing:
// - is-empty, is-full and any refused or empty-listing request answer in the cycle after
//   the transfer; busy stays low, so a request can follow every cycle.
// - peek reads the store in ST_RUN; the result follows the registered read data, with busy high in ST_RUN.
// - a successful add or delete lists the n held values, n up to SLOTS-1, one per cycle;
//   busy stays high while they are read, so no new request is taken until the last value
//   is on the ports; the single store read port sets the one-per-cycle rate.
// - reset clears head and tail; store contents stay undefined, with no clearing pass.
// - results cannot be held off: each stands on the ports for exactly one cycle.
module circular_deque (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [2:0]                         action,
	input  logic signed [cdq_pkg::DATA_W-1:0]  value,
	output logic                               busy,
	output logic                               strobe,
	output logic [2:0]                         kind,
	output logic signed [cdq_pkg::DATA_W-1:0]  value_res,
	output logic                               last
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                       state_q;
	logic [cdq_pkg::IDX_W-1:0]    head_q, tail_q;
	logic [cdq_pkg::IDX_W-1:0]    pos_q;   // next store slot to read
	logic [cdq_pkg::IDX_W-1:0]    rem_q;   // reads still to issue
	logic                         strobe_q, last_q, from_mem_q;
	cdq_pkg::kind_t               kind_q;

	cdq_pkg::wr_req_t             wr;
	cdq_pkg::rd_req_t             rd;
	logic [cdq_pkg::DATA_W-1:0]   rd_data;

	// decode of a request in the idle state
	logic                         accept;
	logic                         empty_w, full_w;
	logic                         dec_run, dec_list;
	cdq_pkg::kind_t               dec_kind;
	logic [cdq_pkg::IDX_W-1:0]    nh, nt, cnt_w;
	logic [cdq_pkg::IDX_W-1:0]    dec_pos, dec_cnt;

	assign accept  = start && (state_q == ST_IDLE);
	assign empty_w = (head_q == tail_q);
	assign full_w  = (head_q == cdq_pkg::wrap_up(tail_q));

	always_comb begin
		nh       = head_q;
		nt       = tail_q;
		dec_run  = 1'b0;
		dec_list = 1'b0;
		dec_kind = cdq_pkg::KIND_VALUE;
		dec_pos  = '0;
		dec_cnt  = '0;
		wr.en    = 1'b0;
		wr.addr  = head_q;
		wr.data  = value;
		case (cdq_pkg::action_t'(action))
			cdq_pkg::ACT_ADD_L: begin
				if (full_w) begin
					dec_kind = cdq_pkg::KIND_FULL;
				end else begin
					wr.en    = accept;
					wr.addr  = head_q;
					nh       = cdq_pkg::wrap_down(head_q);
					dec_list = 1'b1;
				end
			end
			cdq_pkg::ACT_ADD_R: begin
				if (full_w) begin
					dec_kind = cdq_pkg::KIND_FULL;
				end else begin
					nt       = cdq_pkg::wrap_up(tail_q);
					wr.en    = accept;
					wr.addr  = nt;
					dec_list = 1'b1;
				end
			end
			cdq_pkg::ACT_DEL_L: begin
				if (empty_w) begin
					dec_kind = cdq_pkg::KIND_EMPTY;
				end else begin
					nh       = cdq_pkg::wrap_up(head_q);
					dec_list = 1'b1;
				end
			end
			cdq_pkg::ACT_DEL_R: begin
				if (empty_w) begin
					dec_kind = cdq_pkg::KIND_EMPTY;
				end else begin
					nt       = cdq_pkg::wrap_down(tail_q);
					dec_list = 1'b1;
				end
			end
			cdq_pkg::ACT_PEEK_L: begin
				if (empty_w) begin
					dec_kind = cdq_pkg::KIND_EMPTY;
				end else begin
					dec_run = 1'b1;
					dec_pos = cdq_pkg::wrap_up(head_q);
					dec_cnt = cdq_pkg::IDX_W'(1);
				end
			end
			cdq_pkg::ACT_PEEK_R: begin
				if (empty_w) begin
					dec_kind = cdq_pkg::KIND_EMPTY;
				end else begin
					dec_run = 1'b1;
					dec_pos = tail_q;
					dec_cnt = cdq_pkg::IDX_W'(1);
				end
			end
			cdq_pkg::ACT_IS_EMPT: begin
				dec_kind = empty_w ? cdq_pkg::KIND_YES : cdq_pkg::KIND_NO;
			end
			cdq_pkg::ACT_IS_FULL: begin
				dec_kind = full_w ? cdq_pkg::KIND_YES : cdq_pkg::KIND_NO;
			end
			default: begin
				dec_kind = cdq_pkg::KIND_NO;
			end
		endcase

		// listing after a change: all held values from the new left end
		cnt_w = cdq_pkg::occupancy(nh, nt);
		if (dec_list) begin
			if (cnt_w == '0) begin
				dec_kind = cdq_pkg::KIND_NONE_LEFT;
			end else begin
				dec_run = 1'b1;
				dec_pos = cdq_pkg::wrap_up(nh);
				dec_cnt = cnt_w;
			end
		end
	end

	// reads start the cycle after the transfer, so a fresh write is never read in its own cycle
	assign rd.en   = (state_q == ST_RUN);
	assign rd.addr = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			pos_q      <= '0;
			rem_q      <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			from_mem_q <= 1'b0;
			kind_q     <= cdq_pkg::KIND_VALUE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					strobe_q   <= 1'b0;
					from_mem_q <= 1'b0;
					if (accept) begin
						head_q <= nh;
						tail_q <= nt;
						if (dec_run) begin
							pos_q   <= dec_pos;
							rem_q   <= dec_cnt;
							state_q <= ST_RUN;
						end else begin
							// answer without touching the store
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							kind_q   <= dec_kind;
						end
					end
				end
				ST_RUN: begin
					strobe_q   <= 1'b1;
					from_mem_q <= 1'b1;
					kind_q     <= cdq_pkg::KIND_VALUE;
					last_q     <= (rem_q == cdq_pkg::IDX_W'(1));
					pos_q      <= cdq_pkg::wrap_up(pos_q);
					rem_q      <= rem_q - cdq_pkg::IDX_W'(1);
					if (rem_q == cdq_pkg::IDX_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	cdq_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign kind      = kind_q;
	assign last      = last_q;
	assign value_res = from_mem_q ? $signed(rd_data) : '0;

endmodule

// ----- hw/rtl/cdq_checker.sv -----
// cdq_checker: port-level assertions for circular_deque, attached by bind.
// Depends on cdq_pkg and circular_deque.
module cdq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               strobe,
	input logic [2:0]                         kind,
	input logic signed [cdq_pkg::DATA_W-1:0]  value_res,
	input logic                               last
);

	// a listing runs without gaps until its final item
	a_list_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("listing broken before last item");

	// every transfer is followed by an answer or by busy
	a_accept_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("request transfer left without response");

	// only element items can be part of a longer response
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind != 3'(cdq_pkg::KIND_VALUE)) |-> last && (value_res == '0))
		else $error("status result not single or carries a value");

	// leaving busy coincides with the final item of the response
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("busy dropped without final result");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.kind      (kind),
	.value_res (value_res),
	.last      (last)
);

// ----- tb/tb_deque_checker.sv -----
`timescale 1ns / 1ps
// tb_deque_checker: watches the request and result channels of circular_deque,
// keeps a shadow copy of the deque and checks every result in order. Needs cdq_pkg.
module tb_deque_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [2:0]                         action,
	input  logic signed [cdq_pkg::DATA_W-1:0]  value,
	input  logic                               strobe,
	input  logic [2:0]                         kind,
	input  logic signed [cdq_pkg::DATA_W-1:0]  value_res,
	input  logic                               last,
	output int                                 fails,
	output int                                 outstanding,
	output int                                 checked
);
	import cdq_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] data;
		logic              last;
	} answer_t;

	answer_t           answers_due[$];
	logic [DATA_W-1:0] mirror [SLOTS];
	int                head_i;
	int                tail_i;

	function automatic int up1(input int i);
		return (i + 1) % SLOTS;
	endfunction

	function automatic int down1(input int i);
		return (i + SLOTS - 1) % SLOTS;
	endfunction

	task automatic due(input kind_t k, input logic [DATA_W-1:0] d, input logic l);
		answer_t a;
		a.kind = k;
		a.data = d;
		a.last = l;
		answers_due.push_back(a);
	endtask

	// whole contents, left to right, after a successful insert or removal
	task automatic list_contents();
		int n;
		int p;
		n = (tail_i + SLOTS - head_i) % SLOTS;
		p = head_i;
		if (n == 0) begin
			due(KIND_NONE_LEFT, '0, 1'b1);
		end else begin
			for (int k = 0; k < n; k++) begin
				p = up1(p);
				due(KIND_VALUE, mirror[p], k == n - 1);
			end
		end
	endtask

	task automatic apply_request(input action_t act, input logic [DATA_W-1:0] v);
		logic is_empty;
		logic is_full;
		is_empty = (head_i == tail_i);
		is_full  = (head_i == up1(tail_i));
		case (act)
			ACT_ADD_L: begin
				if (is_full) begin
					due(KIND_FULL, '0, 1'b1);
				end else begin
					mirror[head_i] = v;
					head_i = down1(head_i);
					list_contents();
				end
			end
			ACT_ADD_R: begin
				if (is_full) begin
					due(KIND_FULL, '0, 1'b1);
				end else begin
					tail_i = up1(tail_i);
					mirror[tail_i] = v;
					list_contents();
				end
			end
			ACT_DEL_L: begin
				if (is_empty) begin
					due(KIND_EMPTY, '0, 1'b1);
				end else begin
					head_i = up1(head_i);
					list_contents();
				end
			end
			ACT_DEL_R: begin
				if (is_empty) begin
					due(KIND_EMPTY, '0, 1'b1);
				end else begin
					tail_i = down1(tail_i);
					list_contents();
				end
			end
			ACT_PEEK_L: begin
				if (is_empty) due(KIND_EMPTY, '0, 1'b1);
				else due(KIND_VALUE, mirror[up1(head_i)], 1'b1);
			end
			ACT_PEEK_R: begin
				if (is_empty) due(KIND_EMPTY, '0, 1'b1);
				else due(KIND_VALUE, mirror[tail_i], 1'b1);
			end
			ACT_IS_EMPT: begin
				due(is_empty ? KIND_YES : KIND_NO, '0, 1'b1);
			end
			default: begin
				due(is_full ? KIND_YES : KIND_NO, '0, 1'b1);
			end
		endcase
	endtask

	// results first: one landing at the same edge as a new request belongs to an older one
	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		if (!arst_n) begin
			head_i = 0;
			tail_i = 0;
			answers_due.delete();
			fails = 0;
			checked = 0;
			outstanding = 0;
		end else begin
			if (strobe) begin
				if (answers_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with nothing due: kind %0d value %0d last %0d",
							$realtime, kind, value_res, last);
				end else begin
					exp_a = answers_due.pop_front();
					checked++;
					if (kind !== exp_a.kind || value_res !== exp_a.data
							|| last !== exp_a.last) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch: kind %0d/%0d value %0d/%0d last %0d/%0d",
								$realtime, kind, exp_a.kind, value_res,
								$signed(exp_a.data), last, exp_a.last);
					end
				end
			end
			if (start && !busy)
				apply_request(action_t'(action), value);
			outstanding = answers_due.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for circular_deque; the checking lives in tb_deque_checker.
// Needs cdq_pkg, circular_deque and tb_deque_checker.
module tb;
	import cdq_pkg::*;

	// cycles with no transfer on either channel before the run is given up;
	// the longest honest lull is the closing wait at the end of the run, well under this
	localparam int QUIET_LIMIT = 2000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic [2:0]               action;
	logic signed [DATA_W-1:0] value;
	logic                     busy;
	logic                     strobe;
	logic [2:0]               kind;
	logic signed [DATA_W-1:0] value_res;
	logic                     last;

	int fails;
	int outstanding;
	int checked;

	int idle_pct;      // chance in a hundred that the sender skips a cycle
	int held;          // occupancy as the stimulus sees it, used for steering and for counting refused requests
	bit filling;       // random walk leans towards adds while set, deletes otherwise
	int sent;
	int full_hits;
	int empty_hits;
	int quiet;

	circular_deque u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.value     (value),
		.busy      (busy),
		.strobe    (strobe),
		.kind      (kind),
		.value_res (value_res),
		.last      (last)
	);

	tb_deque_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.value       (value),
		.strobe      (strobe),
		.kind        (kind),
		.value_res   (value_res),
		.last        (last),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: counts cycles with neither a request transfer nor a result.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet <= 0;
		end else begin
			if ((start && !busy) || strobe) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles", QUIET_LIMIT);
				$display("circular_deque test failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Edge-heavy values: both extremes, zero and minus one turn up often.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(9))
			0:       v = 32'sh8000_0000;
			1:       v = 32'sh7fff_ffff;
			2:       v = '0;
			3:       v = -1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// One request: optional idle cycles, then start held high until the transfer.
	// Every change happens at a falling edge.
	task automatic send_request(input action_t act, input logic signed [DATA_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start  <= 1'b1;
		action <= act;
		value  <= v;
		// busy read here is the value from before the edge
		do @(posedge clk); while (busy);
		sent++;
		case (act)
			ACT_ADD_L, ACT_ADD_R: begin
				if (held < SLOTS - 1) held++;
				else full_hits++;
			end
			ACT_DEL_L, ACT_DEL_R: begin
				if (held > 0) held--;
				else empty_hits++;
			end
			default: ;
		endcase
	endtask

	// Random walk between empty and full: mostly adds or deletes leaning one
	// way, a quarter queries and peeks, a little noise. Lingers at each end
	// for a while so refused adds and deletes on empty are hit repeatedly.
	task automatic random_phase(input int n_items);
		action_t act;
		int      r;
		bit      grow;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			if (r < 25) begin
				act = action_t'($urandom_range(4, 7));
			end else if (r < 30) begin
				act = action_t'($urandom_range(0, 3));
			end else begin
				grow = ($urandom_range(9) < 8) ? filling : !filling;
				if (grow) act = $urandom_range(1) ? ACT_ADD_R : ACT_ADD_L;
				else act = $urandom_range(1) ? ACT_DEL_R : ACT_DEL_L;
			end
			send_request(act, pick_value());
			if (held == SLOTS - 1 && filling && $urandom_range(3) == 0) filling = 1'b0;
			if (held == 0 && !filling && $urandom_range(3) == 0) filling = 1'b1;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		action     = ACT_ADD_L;
		value      = '0;
		held       = 0;
		filling    = 1'b1;
		sent       = 0;
		full_hits  = 0;
		empty_hits = 0;
		idle_pct   = 13;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: peeks, deletes and both queries on an empty deque, then a few values at the
		// extremes with the first add-left wrapping head below slot zero, peeks
		// at both ends, and a drain back to the empty listing.
		send_request(ACT_PEEK_L, pick_value());
		send_request(ACT_PEEK_R, pick_value());
		send_request(ACT_DEL_L, pick_value());
		send_request(ACT_DEL_R, pick_value());
		send_request(ACT_IS_EMPT, pick_value());
		send_request(ACT_IS_FULL, pick_value());
		send_request(ACT_ADD_L, 32'sh8000_0000);
		send_request(ACT_ADD_R, 32'sh7fff_ffff);
		send_request(ACT_ADD_L, '0);
		send_request(ACT_ADD_R, -1);
		send_request(ACT_PEEK_L, pick_value());
		send_request(ACT_PEEK_R, pick_value());
		send_request(ACT_IS_EMPT, pick_value());
		send_request(ACT_IS_FULL, pick_value());
		send_request(ACT_DEL_L, pick_value());
		send_request(ACT_DEL_R, pick_value());
		send_request(ACT_DEL_L, pick_value());
		send_request(ACT_DEL_R, pick_value());

		// Random: sender lightly idle, then mostly idle, then flat out.
		idle_pct = 13;
		random_phase(120);
		idle_pct = 69;
		random_phase(120);
		idle_pct = 0;
		random_phase(120);

		@(negedge clk);
		start <= 1'b0;

		// drain what is due, then leave room for any stray listing to show up
		while (outstanding != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);

		$display("Ran %0d requests, %0d results checked, %0d mismatches.",
			sent, checked, fails);
		$display("Adds refused on a full deque: %0d; deletes on an empty deque: %0d.",
			full_hits, empty_hits);
		if (fails == 0 && outstanding == 0) begin
			$display("circular_deque test passed");
		end else begin
			$display("circular_deque test failed");
		end
		$finish;
	end

endmodule
